// ===== design/anlp_pkg.sv =====
// ----------------------------------------------------------------------------
// anlp_pkg
// Shared types, character codes and helper functions of the number parser.
// ----------------------------------------------------------------------------
package anlp_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int OUT_VALUE_W         = 32;
    localparam int LEN_W               = 8;
    localparam int CHAR_W              = 8;
    localparam int DIGIT_W             = 5;

    localparam logic [CHAR_W-1:0] CHR_MINUS   = 8'h2d;  // '-'
    localparam logic [CHAR_W-1:0] CHR_ZERO    = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHR_NINE    = 8'h39;  // '9'
    localparam logic [CHAR_W-1:0] CHR_UP_A    = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CHR_UP_F    = 8'h46;  // 'F'
    localparam logic [CHAR_W-1:0] CHR_LO_A    = 8'h61;  // 'a'
    localparam logic [CHAR_W-1:0] CHR_LO_F    = 8'h66;  // 'f'
    localparam logic [CHAR_W-1:0] CHR_LO_X    = 8'h78;  // 'x'
    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 5'd16;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 5'd10;

    typedef enum logic [4:0] {
        MODE_DONE = 5'b00001,
        MODE_ZERO = 5'b00010,
        MODE_HEX  = 5'b00100,
        MODE_DEC  = 5'b01000,
        MODE_NEG  = 5'b10000
    } parse_mode_t;

    typedef struct packed {
        logic [LEN_W-1:0]       length;
        logic [OUT_VALUE_W-1:0] value;
    } parse_result_t;

    function automatic logic is_dec(input logic [CHAR_W-1:0] c);
        return (c >= CHR_ZERO) && (c <= CHR_NINE);
    endfunction

    // digit value, DIGIT_NONE when c is no hex digit
    function automatic logic [DIGIT_W-1:0] hex_val(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        d = DIGIT_NONE;
        if (is_dec(c))
            d = DIGIT_W'(c - CHR_ZERO);
        else if (c >= CHR_LO_A && c <= CHR_LO_F)
            d = DIGIT_W'(c - CHR_LO_A) + DIGIT_TEN;
        else if (c >= CHR_UP_A && c <= CHR_UP_F)
            d = DIGIT_W'(c - CHR_UP_A) + DIGIT_TEN;
        return d;
    endfunction

endpackage

// ===== design/ascii_number_literal_parser_unit.sv =====
// ----------------------------------------------------------------------------
// ascii_number_literal_parser_unit
// Streams ASCII characters in and emits one parsed integer per number.
// ----------------------------------------------------------------------------
// One character per cycle while the output is not stalled. Each beat is captured
// in an input register, the parse update (shift-add accumulator, count, mode) is
// done in one pass, and a result, when the character ends a number, lands in the
// output register. Forms: "0x" hex, unsigned decimal, '-' decimal. Value wraps
// modulo 2^VALUE_WIDTH and is then sign-extended or truncated to 32 bits; length
// wraps at 256.
module ascii_number_literal_parser_unit import anlp_pkg::*; #(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tuser,   // [0] start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] value, [39:32] length
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [CHAR_W-1:0]      ch_reg;
    logic                   start_reg;
    parse_mode_t            mode_reg;
    parse_mode_t            mode_next;
    logic [VALUE_WIDTH-1:0] acc_reg;
    logic [VALUE_WIDTH-1:0] acc_next;
    logic [LEN_W-1:0]       cnt_reg;
    logic [LEN_W-1:0]       cnt_next;
    logic                   emit;
    parse_result_t          result;
    parse_result_t          m_data;
    logic                   can_load;
    logic                   advance;
    logic                   s_beat;

    assign advance  = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || can_load;
    assign s_beat   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_beat)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_DONE;
            acc_reg      <= '0;
            cnt_reg      <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (advance) begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            ch_reg    <= s_tdata;
            start_reg <= s_tuser;
        end
    end

    anlp_step #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_step (
        .ch        (ch_reg),
        .start_req (start_reg),
        .mode      (mode_reg),
        .acc       (acc_reg),
        .cnt       (cnt_reg),
        .mode_next (mode_next),
        .acc_next  (acc_next),
        .cnt_next  (cnt_next),
        .emit      (emit),
        .result    (result)
    );

    anlp_out_buf u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .load_valid (emit),
        .load_data  (result),
        .can_load   (can_load),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_data     (m_data)
    );

    assign m_tdata = {m_data.length, m_data.value};

endmodule

// ===== design/anlp_step.sv =====
// ----------------------------------------------------------------------------
// anlp_step
// Per-character parse update: next mode, accumulator and count, plus result.
// ----------------------------------------------------------------------------
module anlp_step import anlp_pkg::*; #(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  logic [CHAR_W-1:0]      ch,
    input  logic                   start_req,
    input  parse_mode_t            mode,
    input  logic [VALUE_WIDTH-1:0] acc,
    input  logic [LEN_W-1:0]       cnt,
    output parse_mode_t            mode_next,
    output logic [VALUE_WIDTH-1:0] acc_next,
    output logic [LEN_W-1:0]       cnt_next,
    output logic                   emit,
    output parse_result_t          result
);

    logic [VALUE_WIDTH-1:0] dec_digit;
    logic [VALUE_WIDTH-1:0] hex_digit;
    logic [VALUE_WIDTH-1:0] acc_dec;
    logic [VALUE_WIDTH-1:0] acc_hex;
    logic [VALUE_WIDTH-1:0] emit_val;
    logic [DIGIT_W-1:0]     hv;
    logic                   dec_ok;

    assign hv        = hex_val(ch);
    assign dec_ok    = is_dec(ch);
    assign dec_digit = VALUE_WIDTH'(ch - CHR_ZERO);
    assign hex_digit = VALUE_WIDTH'(hv);
    // x10 as shift-add; from zero on a start beat
    assign acc_dec   = start_req ? dec_digit
                                 : (acc << 3) + (acc << 1) + dec_digit;
    assign acc_hex   = (acc << 4) + hex_digit;

    always_comb begin
        mode_next = mode;
        acc_next  = acc;
        cnt_next  = cnt;
        emit      = 1'b0;
        emit_val  = acc;
        if (start_req) begin
            acc_next = '0;
            cnt_next = '0;
            if (ch == CHR_ZERO) begin
                cnt_next  = LEN_W'(1);
                mode_next = MODE_ZERO;
            end else if (ch == CHR_MINUS) begin
                mode_next = MODE_NEG;
            end else if (dec_ok) begin
                acc_next  = acc_dec;
                cnt_next  = LEN_W'(1);
                mode_next = MODE_DEC;
            end else begin
                emit      = 1'b1;
                emit_val  = '0;
                mode_next = MODE_DONE;
            end
        end else begin
            unique case (mode)
                MODE_ZERO: begin
                    if (ch == CHR_LO_X) begin
                        cnt_next  = LEN_W'(2);
                        mode_next = MODE_HEX;
                    end else if (dec_ok) begin
                        acc_next  = acc_dec;
                        cnt_next  = cnt + LEN_W'(1);
                        mode_next = MODE_DEC;
                    end else begin
                        emit      = 1'b1;
                        mode_next = MODE_DONE;
                    end
                end
                MODE_HEX: begin
                    if (hv != DIGIT_NONE) begin
                        acc_next = acc_hex;
                        cnt_next = cnt + LEN_W'(1);
                    end else begin
                        emit      = 1'b1;
                        mode_next = MODE_DONE;
                    end
                end
                MODE_DEC, MODE_NEG: begin
                    if (dec_ok) begin
                        acc_next = acc_dec;
                        cnt_next = cnt + LEN_W'(1);
                    end else begin
                        emit      = 1'b1;
                        if (mode == MODE_NEG)
                            emit_val = '0 - acc;
                        mode_next = MODE_DONE;
                    end
                end
                default: begin
                    mode_next = MODE_DONE;
                end
            endcase
        end
    end

    // sign-extend or truncate to the output width
    assign result.value  = OUT_VALUE_W'(signed'(emit_val));
    assign result.length = cnt_next;

endmodule

// ===== design/anlp_out_buf.sv =====
// ----------------------------------------------------------------------------
// anlp_out_buf
// Result register on the output stream; takes a new result while the old
// one is leaving.
// ----------------------------------------------------------------------------
module anlp_out_buf import anlp_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  logic          load_valid,
    input  parse_result_t load_data,
    output logic          can_load,
    output logic          m_tvalid,
    input  logic          m_tready,
    output parse_result_t m_data
);

    logic          valid_reg;
    logic          valid_next;
    parse_result_t data_reg;

    assign can_load = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load)
            valid_next = load_valid;
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge aclk) begin
        if (load && load_valid)
            data_reg <= load_data;
    end

    assign m_tvalid = valid_reg;
    assign m_data   = data_reg;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for ascii_number_literal_parser_unit. It drives character beats on
// the input stream and checks every result beat against a number predictor
// kept in step with the accepted characters, or against the row's own value for
// typed directed rows. A directed table runs first, then random hex, decimal,
// negative and noise strings under four flow-control phases.
// ----------------------------------------------------------------------------
module tb;
    import anlp_pkg::*;

    localparam int RANDOM_CHARS   = 750;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int MAX_REPORTS    = 40;
    localparam int LONG_DIGITS    = 300;

    typedef struct packed {
        logic [7:0]  ch;
        logic        st;
        logic        typed;
        logic [31:0] value;
        logic [7:0]  len;
    } char_row_t;

    localparam int N_ROWS = 29;
    localparam char_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{"A",        1'b0, 1'b0, 32'h0,        8'd0},   // idle after reset
        '{"Q",        1'b1, 1'b1, 32'h0,        8'd0},   // nothing numeric
        '{CHR_MINUS,  1'b1, 1'b0, 32'h0,        8'd0},
        '{CHR_NINE,   1'b0, 1'b0, 32'h0,        8'd0},
        '{",",        1'b0, 1'b1, 32'hffff_fff7, 8'd1},
        '{CHR_ZERO,   1'b1, 1'b0, 32'h0,        8'd0},   // hex, mixed case, overflow
        '{CHR_LO_X,   1'b0, 1'b0, 32'h0,        8'd0},
        '{CHR_LO_A,   1'b0, 1'b0, 32'h0,        8'd0},
        '{CHR_UP_F,   1'b0, 1'b0, 32'h0,        8'd0},
        '{CHR_ZERO,   1'b0, 1'b0, 32'h0,        8'd0},
        '{CHR_ZERO,   1'b0, 1'b0, 32'h0,        8'd0},
        '{CHR_ZERO,   1'b0, 1'b0, 32'h0,        8'd0},
        '{CHR_ZERO,   1'b0, 1'b0, 32'h0,        8'd0},
        '{CHR_ZERO,   1'b0, 1'b0, 32'h0,        8'd0},
        '{CHR_ZERO,   1'b0, 1'b0, 32'h0,        8'd0},
        '{"1",        1'b0, 1'b0, 32'h0,        8'd0},
        '{"/",        1'b0, 1'b1, 32'hf000_0001, 8'd11},
        '{CHR_ZERO,   1'b1, 1'b0, 32'h0,        8'd0},   // uppercase X ends "0"
        '{"X",        1'b0, 1'b1, 32'h0,        8'd1},
        '{CHR_MINUS,  1'b1, 1'b0, 32'h0,        8'd0},   // bare sign
        '{"z",        1'b0, 1'b1, 32'h0,        8'd0},
        '{CHR_ZERO,   1'b1, 1'b0, 32'h0,        8'd0},   // bare prefix
        '{CHR_LO_X,   1'b0, 1'b0, 32'h0,        8'd0},
        '{":",        1'b0, 1'b1, 32'h0,        8'd2},
        '{"1",        1'b1, 1'b0, 32'h0,        8'd0},
        '{"2",        1'b0, 1'b0, 32'h0,        8'd0},
        '{"5",        1'b1, 1'b0, 32'h0,        8'd0},   // restart drops "12"
        '{8'hff,      1'b0, 1'b1, 32'h5,        8'd1},
        '{8'h00,      1'b0, 1'b0, 32'h0,        8'd0}    // ignored while done
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] ch
    logic        s_tuser  = 1'b0;    // [0] start_req
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;            // [31:0] value, [39:32] length

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int mismatches     = 0;
    int chars_parsed   = 0;
    int numbers_seen   = 0;

    // predictor state
    parse_mode_t num_mode = MODE_DONE;
    logic [31:0] num_acc  = '0;
    logic [7:0]  num_len  = '0;

    parse_result_t pending_numbers [$];

    ascii_number_literal_parser_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit dec_digit(input logic [7:0] c);
        return c >= CHR_ZERO && c <= CHR_NINE;
    endfunction

    // 0..15 for a hex digit, -1 otherwise
    function automatic int hex_digit(input logic [7:0] c);
        int d;
        d = -1;
        if (dec_digit(c))
            d = int'(c) - int'(CHR_ZERO);
        else if (c >= CHR_LO_A && c <= CHR_LO_F)
            d = int'(c) - int'(CHR_LO_A) + 10;
        else if (c >= CHR_UP_A && c <= CHR_UP_F)
            d = int'(c) - int'(CHR_UP_A) + 10;
        return d;
    endfunction

    function automatic void add_decimal(input logic [7:0] c);
        num_acc = 32'(num_acc * 32'd10 + 32'(c - CHR_ZERO));
        num_len = num_len + 8'd1;
    endfunction

    // advances the number state by one character; returns 1 when a number ends
    function automatic bit parse_number_char(input logic [7:0] c, input logic st,
                                             output parse_result_t res);
        bit ends;
        int hd;
        ends = 1'b0;
        res  = '0;
        if (st) begin
            num_acc = '0;
            num_len = '0;
            if (c == CHR_ZERO) begin
                num_len  = 8'd1;
                num_mode = MODE_ZERO;
            end else if (c == CHR_MINUS) begin
                num_mode = MODE_NEG;
            end else if (dec_digit(c)) begin
                add_decimal(c);
                num_mode = MODE_DEC;
            end else begin
                num_mode = MODE_DONE;
                ends     = 1'b1;
            end
        end else begin
            case (num_mode)
                MODE_ZERO: begin
                    if (c == CHR_LO_X) begin
                        num_len  = 8'd2;
                        num_mode = MODE_HEX;
                    end else if (dec_digit(c)) begin
                        add_decimal(c);
                        num_mode = MODE_DEC;
                    end else begin
                        ends = 1'b1;
                    end
                end
                MODE_HEX: begin
                    hd = hex_digit(c);
                    if (hd >= 0) begin
                        num_acc = {num_acc[27:0], 4'(hd)};
                        num_len = num_len + 8'd1;
                    end else begin
                        ends = 1'b1;
                    end
                end
                MODE_DEC, MODE_NEG: begin
                    if (dec_digit(c))
                        add_decimal(c);
                    else
                        ends = 1'b1;
                end
                default: ;
            endcase
        end
        if (ends) begin
            res.value  = (num_mode == MODE_NEG) ? 32'(32'd0 - num_acc) : num_acc;
            res.length = num_len;
            num_mode   = MODE_DONE;
        end
        return ends;
    endfunction

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("tb: mismatch in %s: got %h, expected %h at %0t",
                     what, got, want, $time);
    endtask

    task automatic check_number(input parse_result_t got);
        parse_result_t want;
        numbers_seen++;
        if (pending_numbers.size() == 0) begin
            report_mismatch("result with nothing pending", got, '0);
        end else begin
            want = pending_numbers.pop_front();
            if (got.value !== want.value)
                report_mismatch("value", 40'(got.value), 40'(want.value));
            if (got.length !== want.length)
                report_mismatch("length", 40'(got.length), 40'(want.length));
        end
    endtask

    // one character beat; typed rows carry their own expected number
    task automatic push_char(input logic [7:0] c, input logic st, input bit typed,
                             input parse_result_t want);
        parse_result_t guess;
        bit ends;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= st;
        do @(posedge aclk); while (!s_tready);
        ends = parse_number_char(c, st, guess);
        chars_parsed++;
        if (typed)
            pending_numbers.push_back(want);
        else if (ends)
            pending_numbers.push_back(guess);
    endtask

    task automatic feed(input logic [7:0] c, input logic st);
        push_char(c, st, 1'b0, '0);
    endtask

    function automatic logic [7:0] dec_char();
        return 8'(CHR_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic logic [7:0] pick_hex_digit();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    // one random string: well-formed number mostly, noise now and then
    task automatic send_number(input bit long_run);
        int form;
        int ndig;
        int tries;
        form = $urandom_range(0, 9);
        ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 14) : $urandom_range(0, 4);
        if (long_run) begin
            form = 6;
            ndig = LONG_DIGITS;   // length field wraps past 255
        end
        if (form <= 3) begin
            feed(dec_char(), 1'b1);
            repeat (ndig) feed(dec_char(), 1'b0);
        end else if (form <= 5) begin
            feed(CHR_MINUS, 1'b1);
            repeat (ndig) feed(dec_char(), 1'b0);
        end else if (form <= 7) begin
            feed(CHR_ZERO, 1'b1);
            feed(CHR_LO_X, 1'b0);
            repeat (ndig) feed(pick_hex_digit(), 1'b0);
        end else if (form == 8) begin
            feed(CHR_ZERO, 1'b1);
            repeat (ndig) feed(dec_char(), 1'b0);
        end else begin
            repeat ($urandom_range(1, 6))
                feed(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
        // 1 in 8 left open, so the next start cuts it off
        if ($urandom_range(0, 7) != 0) begin
            tries = 0;
            while (num_mode != MODE_DONE && tries < 4) begin
                feed(8'($urandom_range(0, 255)), 1'b0);
                tries++;
            end
        end
        repeat ($urandom_range(0, 2)) feed(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // result side: checks, backpressure, activity for the watchdog
    initial begin
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (aresetn && m_tvalid && m_tready)
                check_number(m_tdata);
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("tb: timeout, %0d numbers still pending", pending_numbers.size());
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        int base;
        int seq;
        int phase;
        int skew;
        int mark;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_ROWS; i++)
            push_char(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].st, DIRECTED_ROWS[i].typed,
                      '{length: DIRECTED_ROWS[i].len, value: DIRECTED_ROWS[i].value});

        base = chars_parsed;
        seq  = 0;
        skew = 0;
        while (chars_parsed - base < RANDOM_CHARS) begin
            phase = (chars_parsed - base - skew) * 4 / (RANDOM_CHARS - skew);
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            mark = chars_parsed;
            send_number(seq == 12);
            // the long run stays out of the phase split
            if (seq == 12)
                skew = chars_parsed - mark;
            seq++;
        end
        s_tvalid <= 1'b0;

        while (pending_numbers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb: %0d character beats sent, %0d numbers returned, %0d mismatches",
                 chars_parsed, numbers_seen, mismatches);
        $display("tb: covered hex, decimal, negative and noise strings under 4 idle mixes");
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/anlp_pkg.sv
design/anlp_step.sv
design/anlp_out_buf.sv
design/ascii_number_literal_parser_unit.sv
sim/tb.sv
